### hdl/imt_pkg.sv
// ----------------------------------------------------------------------------
// imt_pkg: shared types and constants of the IO mapping table
// Domain and entry counts, request modes, status codes and the request
// bundle that the controller broadcasts along the row of entry cells.
// ----------------------------------------------------------------------------
package imt_pkg;

  localparam int unsigned DomainCount = 16;
  localparam int unsigned EntryCount  = 256;
  localparam int unsigned DomW        = (DomainCount > 1) ? $clog2(DomainCount) : 1;
  localparam int unsigned CntW        = (EntryCount > 1) ? $clog2(EntryCount) : 1;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_CREATE = 3'd1,
    MODE_CHECK  = 3'd2,
    MODE_MAP    = 3'd3,
    MODE_UNMAP  = 3'd4,
    MODE_PASS   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DEFERRED  = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_MEMORY = 3'd4
  } status_e;

  // request held steady while a wave runs down the cell row
  typedef struct packed {
    logic            clr;        // init: drop every entry
    logic            free_pass;  // wave looks for a free entry, not a match
    logic            is_map;     // map writes on a hit, unmap clears
    logic [DomW-1:0] dom;
    logic [63:0]     ioa;
    logic [63:0]     pa;
    logic [63:0]     len;
    logic [7:0]      perm;
  } req_t;

endpackage

### hdl/iommu_map_table.sv
// ----------------------------------------------------------------------------
// iommu_map_table: mapping table of an IO memory management unit
// Domain bookkeeping in a controller; the mapping entries sit in a row of
// cells that a search wave walks one cell per cycle.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | mode, domain, addresses, ...
//   out     | output    | out_valid_o/out_ready_i| status, new_domain
//
// Init, create, check, set passthrough and every error found by the decoder
// are answered without a wave. Map and unmap run a match wave down the row;
// a map that finds no match runs a second wave for a free entry.
// Reset leaves the table uninitialised; no clearing pass is needed.
// A result waiting in the output register holds off the next item.
// ----------------------------------------------------------------------------
module iommu_map_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  domain_i,
  input  logic [63:0] io_address_i,
  input  logic [63:0] phys_address_i,
  input  logic [63:0] length_i,
  input  logic [7:0]  permission_i,
  input  logic        enable_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  new_domain_o
);
  import imt_pkg::*;

  req_t                req;
  logic [EntryCount:0] wave;

  imt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .domain_i      (domain_i),
    .io_address_i  (io_address_i),
    .phys_address_i(phys_address_i),
    .length_i      (length_i),
    .permission_i  (permission_i),
    .enable_i      (enable_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .new_domain_o  (new_domain_o),
    .req_o         (req),
    .start_o       (wave[0]),
    .wave_end_i    (wave[EntryCount])
  );

  // row of entry cells, lowest entry first
  for (genvar g = 0; g < EntryCount; g++) begin : g_cell
    imt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .req_i (req),
      .wave_i(wave[g]),
      .wave_o(wave[g+1])
    );
  end

endmodule

### hdl/imt_cell.sv
// ----------------------------------------------------------------------------
// imt_cell: one entry of the mapping table
// Holds one mapping and one stage of the search wave. A wave that hits
// here does the map or unmap and stops; otherwise it moves on a cell.
// ----------------------------------------------------------------------------
module imt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  imt_pkg::req_t req_i,
  input  logic          wave_i,
  output logic          wave_o
);
  import imt_pkg::*;

  logic            valid_q, wave_q;
  logic [DomW-1:0] dom_q;
  logic [63:0]     ioa_q, pa_q, len_q;
  logic [7:0]      perm_q;
  logic            hit;

  // match against the broadcast request, or free slot on the second pass
  assign hit = wave_q & (req_i.free_pass ? ~valid_q
                                         : (valid_q && dom_q == req_i.dom && ioa_q == req_i.ioa));
  assign wave_o = wave_q & ~hit;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= 1'b0;
    end else begin
      wave_q <= wave_i;
      if (req_i.clr) begin
        valid_q <= 1'b0;
      end else if (hit) begin
        valid_q <= req_i.is_map;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (hit && req_i.is_map) begin
      dom_q  <= req_i.dom;
      ioa_q  <= req_i.ioa;
      pa_q   <= req_i.pa;
      len_q  <= req_i.len;
      perm_q <= req_i.perm;
    end
  end

endmodule

### hdl/imt_ctrl.sv
// ----------------------------------------------------------------------------
// imt_ctrl: request decoder and sequencer of the mapping table
// Keeps the domain state, answers domain requests at once and launches
// search waves down the cell row for map and unmap.
// ----------------------------------------------------------------------------
module imt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            mode_i,
  input  logic [7:0]            domain_i,
  input  logic [63:0]           io_address_i,
  input  logic [63:0]           phys_address_i,
  input  logic [63:0]           length_i,
  input  logic [7:0]            permission_i,
  input  logic                  enable_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [3:0]            new_domain_o,
  output imt_pkg::req_t         req_o,
  output logic                  start_o,
  input  logic                  wave_end_i
);
  import imt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_FREE = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic                   init_q, init_d;
  logic [DomainCount-1:0] used_q, used_d;
  logic [DomainCount-1:0] pass_q, pass_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovld_q, ovld_d;
  logic [2:0]             stat_q, stat_d;
  logic [3:0]             newd_q, newd_d;
  req_t                   req_q, req_d;
  logic                   acc, dom_ok, free_any, last;
  logic [DomW-1:0]        dom_idx, free_idx;

  assign in_ready_o   = (state_q == S_IDLE) && (!ovld_q || out_ready_i);
  assign acc          = in_valid_i && in_ready_o;
  assign out_valid_o  = ovld_q;
  assign status_o     = stat_q;
  assign new_domain_o = newd_q;
  // cells see the registered request, from the cycle after the wave start
  assign req_o        = req_q;
  assign last         = (cnt_q == CntW'(EntryCount - 1));

  // domain lookup
  assign dom_idx = DomW'(domain_i);
  assign dom_ok  = ({1'b0, domain_i} < 9'(DomainCount)) && used_q[dom_idx];

  // lowest free domain
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = DomainCount - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = DomW'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    used_d    = used_q;
    pass_d    = pass_q;
    cnt_d     = cnt_q + CntW'(1);
    ovld_d    = ovld_q && !out_ready_i;
    stat_d    = stat_q;
    newd_d    = newd_q;
    req_d     = req_q;
    req_d.clr = 1'b0;
    start_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          ovld_d = 1'b1;
          stat_d = ST_OK;
          newd_d = '0;
          if (mode_i > MODE_PASS) begin
            stat_d = ST_INVALID;
          end else if (mode_i == MODE_INIT) begin
            init_d    = 1'b1;
            used_d    = '0;
            pass_d    = '1;
            req_d.clr = 1'b1;
          end else if (!init_q) begin
            stat_d = ST_DEFERRED;
          end else if (mode_i == MODE_CREATE) begin
            if (free_any) begin
              used_d[free_idx] = 1'b1;
              pass_d[free_idx] = 1'b1;
              newd_d = 4'(free_idx);
            end else begin
              stat_d = ST_NO_MEMORY;
            end
          end else if (!dom_ok) begin
            stat_d = ST_NOT_FOUND;
          end else if (mode_i == MODE_CHECK) begin
            stat_d = ST_OK;
          end else if (mode_i == MODE_PASS) begin
            pass_d[dom_idx] = enable_i;
          end else if (length_i == 64'd0) begin
            stat_d = ST_INVALID;
          end else begin
            // map or unmap: launch the match wave
            ovld_d          = 1'b0;
            start_o         = 1'b1;
            cnt_d           = '0;
            state_d         = S_FIND;
            req_d.free_pass = 1'b0;
            req_d.is_map    = (mode_i == MODE_MAP);
            req_d.dom       = dom_idx;
            req_d.ioa       = io_address_i;
            req_d.pa        = phys_address_i;
            req_d.len       = length_i;
            req_d.perm      = permission_i;
          end
        end
      end
      S_FIND: begin
        if (last) begin
          if (!wave_end_i) begin
            ovld_d  = 1'b1;
            stat_d  = ST_OK;
            state_d = S_IDLE;
          end else if (req_q.is_map) begin
            // no match: second wave takes the lowest free entry
            start_o         = 1'b1;
            cnt_d           = '0;
            req_d.free_pass = 1'b1;
            state_d         = S_FREE;
          end else begin
            ovld_d  = 1'b1;
            stat_d  = ST_NOT_FOUND;
            state_d = S_IDLE;
          end
        end
      end
      S_FREE: begin
        if (last) begin
          ovld_d  = 1'b1;
          stat_d  = wave_end_i ? ST_NO_MEMORY : ST_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b0;
      used_q  <= '0;
      pass_q  <= '1;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      used_q  <= used_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      req_q   <= req_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    newd_q <= newd_d;
  end

endmodule

### verif/tb_iommu_map_table.sv
// ----------------------------------------------------------------------------
// tb_iommu_map_table: self-checking bench for the IO mapping table
// Requests go in through the input handshake with random gaps, and a
// scoreboard class predicts status and new domain from its own copy of the
// domain and entry state. Each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_iommu_map_table;
  import imt_pkg::*;

  localparam int unsigned NumDom = 16;
  localparam int unsigned NumEnt = 256;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  dom;
    logic [63:0] ioa;
    logic [63:0] pa;
    logic [63:0] len;
    logic [7:0]  perm;
    logic        en;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] new_dom;
  } answer_t;

  // Scoreboard: mapping table predictor and queue of expected answers
  class map_table_sb;
    bit          ready_flag;
    bit          dom_used[NumDom];
    bit          dom_pass[NumDom];
    bit          ent_valid[NumEnt];
    logic [3:0]  ent_dom[NumEnt];
    logic [63:0] ent_ioa[NumEnt];
    answer_t     answers_q[$];
    int          errors;

    function void clear_table();
      for (int k = 0; k < NumDom; k++) begin
        dom_used[k] = 1'b0;
        dom_pass[k] = 1'b1;
      end
      for (int k = 0; k < NumEnt; k++) ent_valid[k] = 1'b0;
    endfunction

    function int find_mapping(logic [7:0] d, logic [63:0] a);
      for (int k = 0; k < NumEnt; k++)
        if (ent_valid[k] && {4'd0, ent_dom[k]} == d && ent_ioa[k] == a) return k;
      return NumEnt;
    endfunction

    // Note one accepted item and queue its expected answer
    function void note_request(request_t r);
      answer_t a;
      int k;
      a.status  = ST_OK;
      a.new_dom = '0;
      if (r.mode > MODE_PASS) a.status = ST_INVALID;
      else if (r.mode == MODE_INIT) begin
        ready_flag = 1'b1;
        clear_table();
      end else if (!ready_flag) a.status = ST_DEFERRED;
      else if (r.mode == MODE_CREATE) begin
        a.status = ST_NO_MEMORY;
        for (k = 0; k < NumDom; k++) begin
          if (!dom_used[k]) begin
            dom_used[k] = 1'b1;
            dom_pass[k] = 1'b1;
            a.new_dom = k[3:0];
            a.status = ST_OK;
            break;
          end
        end
      end else if (r.dom >= NumDom || !dom_used[r.dom]) a.status = ST_NOT_FOUND;
      else if (r.mode == MODE_CHECK) a.status = ST_OK;
      else if (r.mode == MODE_PASS) dom_pass[r.dom] = r.en;
      else if (r.len == 0) a.status = ST_INVALID;
      else if (r.mode == MODE_MAP) begin
        k = find_mapping(r.dom, r.ioa);
        if (k >= NumEnt)
          for (k = 0; k < NumEnt; k++) if (!ent_valid[k]) break;
        if (k < NumEnt) begin
          ent_valid[k] = 1'b1;
          ent_dom[k] = r.dom[3:0];
          ent_ioa[k] = r.ioa;
        end else a.status = ST_NO_MEMORY;
      end else begin
        k = find_mapping(r.dom, r.ioa);
        if (k < NumEnt) ent_valid[k] = 1'b0;
        else a.status = ST_NOT_FOUND;
      end
      answers_q.push_back(a);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_answer(logic [2:0] st, logic [3:0] nd);
      answer_t a;
      if (answers_q.size() == 0) begin
        $error("result with nothing expected: status %0d new_domain %0d", st, nd);
        errors++;
        return;
      end
      a = answers_q.pop_front();
      if (st !== a.status) begin
        $error("status: expected %0d, actual %0d", a.status, st);
        errors++;
      end
      if (nd !== a.new_dom) begin
        $error("new_domain: expected %0d, actual %0d", a.new_dom, nd);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0]  mode_i, status_o;
  logic [7:0]  domain_i, permission_i;
  logic [63:0] io_address_i, phys_address_i, length_i;
  logic        enable_i;
  logic [3:0]  new_domain_o;

  map_table_sb sb;
  int          send_idle_pct, recv_stall_pct;

  iommu_map_table uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Limit: room for the slowest item, a map that runs two waves, plus gaps and stalls
  initial begin
    #(12 * 4000000);
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, sample at the rising edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_answer(status_o, new_domain_o);

  // Drive one item and wait for acceptance; valid stays up for the next item
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= r.mode;
    domain_i       <= r.dom;
    io_address_i   <= r.ioa;
    phys_address_i <= r.pa;
    length_i       <= r.len;
    permission_i   <= r.perm;
    enable_i       <= r.en;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic request_t make_request(logic [2:0] m, logic [7:0] d,
                                            logic [63:0] a, logic [63:0] l);
    request_t r;
    r.mode = m;
    r.dom  = d;
    r.ioa  = a;
    r.pa   = rand64();
    r.len  = l;
    r.perm = 8'($urandom());
    r.en   = 1'($urandom());
    return r;
  endfunction

  // Random item, mostly well-formed, with in-range domains and a small key pool
  function automatic request_t random_request();
    int p;
    logic [2:0]  m;
    logic [7:0]  d;
    logic [63:0] a, l;
    p = $urandom_range(99);
    if (p < 3) m = MODE_INIT;
    else if (p < 9) m = MODE_CREATE;
    else if (p < 14) m = MODE_CHECK;
    else if (p < 60) m = MODE_MAP;
    else if (p < 88) m = MODE_UNMAP;
    else if (p < 95) m = MODE_PASS;
    else m = 3'($urandom_range(7));
    d = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(NumDom - 1));
    a = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(23)) << 12;
    l = ($urandom_range(19) == 0) ? 64'd0 : rand64();
    return make_request(m, d, a, l);
  endfunction

  // Wait until every expected result has arrived
  task automatic drain();
    do @(negedge clk_i); while (sb.answers_q.size() != 0);
  endtask

  initial begin
    request_t r;
    sb = new();
    sb.clear_table();
    sb.ready_flag = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    domain_i = '0;
    io_address_i = '0;
    phys_address_i = '0;
    length_i = '0;
    permission_i = '0;
    enable_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: before init, unknown modes, create, field extremes
    send_request(make_request(MODE_CREATE, 8'd0, 64'd0, 64'd1));
    send_request(make_request(MODE_MAP, 8'd0, 64'd0, 64'd1));
    send_request(make_request(3'd6, 8'd0, 64'd0, 64'd1));
    send_request(make_request(MODE_INIT, 8'hff, '1, '1));
    send_request(make_request(3'd7, 8'd0, 64'd0, 64'd1));
    repeat (17) send_request(make_request(MODE_CREATE, 8'd0, 64'd0, 64'd1));
    send_request(make_request(MODE_CHECK, 8'd15, 64'd0, 64'd1));
    send_request(make_request(MODE_CHECK, 8'd16, 64'd0, 64'd1));
    send_request(make_request(MODE_CHECK, 8'd255, 64'd0, 64'd1));
    r = make_request(MODE_PASS, 8'd3, 64'd0, 64'd1);
    r.en = 1'b0;
    send_request(r);
    send_request(make_request(MODE_MAP, 8'd2, '1, 64'd0));
    send_request(make_request(MODE_MAP, 8'd2, '1, '1));
    send_request(make_request(MODE_MAP, 8'd2, '1, 64'd5));
    send_request(make_request(MODE_UNMAP, 8'd2, '1, 64'd0));
    send_request(make_request(MODE_UNMAP, 8'd2, '1, 64'd9));
    send_request(make_request(MODE_UNMAP, 8'd2, '1, 64'd9));
    // Fill the table to the last entry, then overflow it
    for (int k = 0; k < NumEnt + 2; k++)
      send_request(make_request(MODE_MAP, 8'(k % 4), 64'(k) << 8, 64'd1));
    send_request(make_request(MODE_INIT, 8'd0, 64'd0, 64'd1));
    in_valid_i <= 1'b0;
    drain();

    // Random phases with different idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      send_request(make_request(MODE_INIT, 8'd0, 64'd0, 64'd1));
      repeat (4) send_request(make_request(MODE_CREATE, 8'd0, 64'd0, 64'd1));
      repeat (180) send_request(random_request());
    end
    in_valid_i <= 1'b0;

    drain();
    repeat (600) @(negedge clk_i);
    if (sb.errors == 0 && sb.answers_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/imt_pkg.sv
hdl/imt_cell.sv
hdl/imt_ctrl.sv
hdl/iommu_map_table.sv
verif/tb_iommu_map_table.sv
